// File: design/block_resequencer_macros.svh
// assertion macros shared by the checker
// no dependencies
`ifndef BLOCK_RESEQUENCER_MACROS_SVH
`define BLOCK_RESEQUENCER_MACROS_SVH
`define BRS_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define BRS_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// File: design/brs_pkg.sv
// package for the block resequencer: widths, status codes, state enum
// no dependencies
package brs_pkg;
    localparam int OFF_W  = 40;
    localparam int HND_W  = 8;
    localparam int SIZE_W = 31;
    localparam int TOT_W  = 41;
    localparam int PENDING_DEPTH = 63;
    localparam logic [SIZE_W-1:0] BLOCK_SIZE_RST = 31'd1048576;
    localparam logic [OFF_W-1:0]  STOP_LIMIT_RST = 40'd17179869184;

    typedef enum logic [1:0] {
        ST_RELEASED = 2'd0,
        ST_DUP      = 2'd1,
        ST_FULL     = 2'd2,
        ST_DONE     = 2'd3
    } t_status;

    typedef enum logic {
        REG_BLOCK_SIZE = 1'b0,
        REG_STOP_LIMIT = 1'b1
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE, S_SEARCH, S_EMIT, S_HOLD
    } t_state;

    // command from sequencer to the cell chain
    typedef struct packed {
        logic             clear_match;
        logic             insert;
        logic [OFF_W-1:0] key;
        logic [HND_W-1:0] handle;
    } t_cell_cmd;

    // per-cell status
    typedef struct packed {
        logic             valid;
        logic             match;
        logic [OFF_W-1:0] offset;
        logic [HND_W-1:0] handle;
    } t_cell_stat;
endpackage

// File: design/block_resequencer.sv
// block resequencer top level: sequencer, registers and output stage
// depends on brs_pkg, brs_chain
//
//  channel | dir | handshake        | beat
//  in      | in  | valid / stall    | block_offset, block_handle
//  out     | out | valid / stall    | status, handle, offset, size, done, last
//  cfg     | in  | valid / ready    | index, data
//
// an item is taken in the idle state and looked up in the search state, so a block
// that waits or is rejected returns to idle after the search. a run of releases adds
// one emit-state compare per follower and a final compare that finds none.
// the chain compares all cells in parallel, combinationally.
// reset is synchronous; no clearing pass. output stall holds the result
// register and the sequencer waits for it to drain.
module block_resequencer #(
    parameter int PENDING_DEPTH = brs_pkg::PENDING_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [brs_pkg::OFF_W-1:0]   i_block_offset,
    input  logic [brs_pkg::HND_W-1:0]   i_block_handle,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_status,
    output logic [brs_pkg::HND_W-1:0]   o_out_handle,
    output logic [brs_pkg::OFF_W-1:0]   o_out_offset,
    output logic [brs_pkg::SIZE_W-1:0]  o_out_size,
    output logic                        o_done_res,
    output logic                        o_last_of_run,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [brs_pkg::OFF_W-1:0]   i_cfg_data
);
    localparam int OW = brs_pkg::OFF_W;
    localparam int HW = brs_pkg::HND_W;
    localparam int SW = brs_pkg::SIZE_W;
    localparam int TW = brs_pkg::TOT_W;

    brs_pkg::t_state r_state, n_state;
    logic [SW-1:0] r_block_size;
    logic [OW-1:0] r_stop_limit;
    logic [OW-1:0] r_expected, n_expected;
    logic [TW-1:0] r_total, n_total;
    logic          r_finished, n_finished;
    logic [OW-1:0] r_off, n_off;     // current item or next key
    logic [HW-1:0] r_hnd, n_hnd;
    logic          r_ov, n_ov;
    logic [1:0]    r_st, n_st;
    logic [HW-1:0] r_oh, n_oh;
    logic [OW-1:0] r_oo, n_oo;
    logic [SW-1:0] r_os, n_os;
    logic          r_od, n_od, r_ol, n_ol;

    brs_pkg::t_cell_cmd w_cmd;
    logic          w_any, w_full;
    logic [HW-1:0] w_mh;
    logic [TW:0]   w_sum;
    logic [TW-1:0] w_tot;
    logic          w_fin;
    logic          w_out_free;

    brs_chain #(.DEPTH(PENDING_DEPTH)) u_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_any_match    (w_any),
        .o_full         (w_full),
        .o_match_handle (w_mh)
    );

    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = (r_state != brs_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == brs_pkg::S_IDLE) && !r_ov;

    // saturating running total for one release
    assign w_sum = {1'b0, r_total} + {{(TW + 1 - SW){1'b0}}, r_block_size};
    assign w_tot = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];
    assign w_fin = w_tot > {1'b0, r_stop_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= brs_pkg::S_IDLE;
            r_block_size <= brs_pkg::BLOCK_SIZE_RST;
            r_stop_limit <= brs_pkg::STOP_LIMIT_RST;
            r_expected   <= '0;
            r_total      <= '0;
            r_finished   <= 1'b0;
            r_ov         <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_expected <= n_expected;
            r_total    <= n_total;
            r_finished <= n_finished;
            r_ov       <= n_ov;
            if (i_cfg_valid && o_cfg_ready) begin
                case (brs_pkg::t_reg_idx'(i_cfg_index))
                    brs_pkg::REG_BLOCK_SIZE: r_block_size <= i_cfg_data[SW-1:0];
                    brs_pkg::REG_STOP_LIMIT: r_stop_limit <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_off <= n_off;
        r_hnd <= n_hnd;
        r_st  <= n_st;
        r_oh  <= n_oh;
        r_oo  <= n_oo;
        r_os  <= n_os;
        r_od  <= n_od;
        r_ol  <= n_ol;
    end

    always_comb begin
        n_state    = r_state;
        n_expected = r_expected;
        n_total    = r_total;
        n_finished = r_finished;
        n_off      = r_off;
        n_hnd      = r_hnd;
        n_ov       = r_ov && i_stall;
        n_st = r_st; n_oh = r_oh; n_oo = r_oo; n_os = r_os; n_od = r_od; n_ol = r_ol;
        w_cmd = '{clear_match: 1'b0, insert: 1'b0, key: r_off, handle: r_hnd};
        case (r_state)
            brs_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_off   = i_block_offset;
                    n_hnd   = i_block_handle;
                    n_state = brs_pkg::S_SEARCH;
                end
            end
            brs_pkg::S_SEARCH: begin
                if (w_out_free) begin
                    n_state = brs_pkg::S_IDLE;
                    n_oh = r_hnd; n_oo = r_off; n_os = '0; n_od = 1'b0; n_ol = 1'b1;
                    if (r_finished) begin
                        n_ov = 1'b1; n_st = brs_pkg::ST_DONE; n_od = 1'b1;
                    end else if (r_off == r_expected) begin
                        // release arrival, then look up the follower
                        n_ov = 1'b1; n_st = brs_pkg::ST_RELEASED;
                        n_os = w_fin ? '0 : r_block_size;
                        n_od = w_fin;
                        n_total = w_tot; n_finished = w_fin;
                        n_expected = r_off + {{(OW - SW){1'b0}}, r_block_size};
                        n_off = n_expected;
                        n_ol = 1'b0;
                        n_state = brs_pkg::S_EMIT;
                    end else if (r_off < r_expected || w_any) begin
                        n_ov = 1'b1; n_st = brs_pkg::ST_DUP;
                    end else if (w_full) begin
                        n_ov = 1'b1; n_st = brs_pkg::ST_FULL;
                    end else begin
                        w_cmd.insert = 1'b1;
                    end
                end
            end
            brs_pkg::S_EMIT: begin
                // r_off holds expected; previous result sits in the output reg
                if (!w_any) begin
                    // no follower: the held beat goes out as the last of the run
                    if (w_out_free) begin
                        n_ov = 1'b0;
                        n_state = brs_pkg::S_IDLE;
                    end else begin
                        n_ov = 1'b1;
                    end
                end else if (w_out_free) begin
                    w_cmd.clear_match = 1'b1;
                    n_ov = 1'b1; n_st = brs_pkg::ST_RELEASED;
                    n_oh = w_mh; n_oo = r_off;
                    n_os = w_fin ? '0 : r_block_size;
                    n_od = w_fin; n_ol = 1'b0;
                    n_total = w_tot; n_finished = w_fin;
                    n_expected = r_off + {{(OW - SW){1'b0}}, r_block_size};
                    n_off = n_expected;
                end
            end
            default: n_state = brs_pkg::S_IDLE;
        endcase
    end

    // the last flag is decided one compare ahead: if the follower is absent,
    // the held beat is the last of the run
    assign o_valid       = r_ov;
    assign o_status      = r_st;
    assign o_out_handle  = r_oh;
    assign o_out_offset  = r_oo;
    assign o_out_size    = r_os;
    assign o_done_res    = r_od;
    assign o_last_of_run = r_ol || (r_state == brs_pkg::S_EMIT && !w_any);
endmodule

// File: design/brs_cell.sv
// one store cell: holds an offset and handle, compares against the key
// depends on brs_pkg
module brs_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brs_pkg::t_cell_cmd   i_cmd,
    input  logic                 i_free_in,  // an earlier cell is free
    output logic                 o_free_out,
    output brs_pkg::t_cell_stat  o_stat
);
    logic                     r_valid;
    logic [brs_pkg::OFF_W-1:0] r_offset;
    logic [brs_pkg::HND_W-1:0] r_handle;
    logic                     w_match;
    logic                     w_take;

    assign w_match    = r_valid && (r_offset == i_cmd.key);
    assign w_take     = i_cmd.insert && !r_valid && !i_free_in;
    assign o_free_out = i_free_in || !r_valid;
    assign o_stat     = '{valid: r_valid, match: w_match, offset: r_offset, handle: r_handle};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd.clear_match && w_match) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_offset <= i_cmd.key;
            r_handle <= i_cmd.handle;
        end
    end
endmodule

// File: design/brs_chain.sv
// row of store cells with free-slot chain and match collection
// depends on brs_pkg, brs_cell
module brs_chain #(
    parameter int DEPTH = brs_pkg::PENDING_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  brs_pkg::t_cell_cmd         i_cmd,
    output logic                       o_any_match,
    output logic                       o_full,
    output logic [brs_pkg::HND_W-1:0]  o_match_handle
);
    brs_pkg::t_cell_stat w_stat [DEPTH];
    logic [DEPTH:0]      w_free;
    logic [DEPTH-1:0]    w_m;
    logic [brs_pkg::HND_W-1:0] w_h;

    assign w_free[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        brs_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (i_cmd),
            .i_free_in  (w_free[g]),
            .o_free_out (w_free[g+1]),
            .o_stat     (w_stat[g])
        );
        assign w_m[g] = w_stat[g].match;
    end

    // offsets in store are unique, so at most one match: or-reduce handles
    always_comb begin
        w_h = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_h = w_h | (w_stat[k].match ? w_stat[k].handle : '0);
        end
    end

    assign o_any_match    = |w_m;
    assign o_full         = !w_free[DEPTH];
    assign o_match_handle = w_h;
endmodule

// File: design/brs_checker.sv
// port-level checker for the block resequencer
// depends on brs_pkg and block_resequencer_macros.svh
`include "block_resequencer_macros.svh"
module brs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [1:0]                 o_status,
    input logic [brs_pkg::SIZE_W-1:0] o_out_size,
    input logic                       o_done_res,
    input logic                       o_last_of_run
);
    `BRS_ASSERT_IMP(a_rej_last, i_clk, i_rst_n, o_valid && o_status != brs_pkg::ST_RELEASED, o_last_of_run)
    `BRS_ASSERT_IMP(a_rej_size, i_clk, i_rst_n, o_valid && o_status != brs_pkg::ST_RELEASED, o_out_size == '0)
    `BRS_ASSERT_IMP(a_done_st, i_clk, i_rst_n, o_valid && o_status == brs_pkg::ST_DONE, o_done_res)
    `BRS_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_status))
endmodule

bind block_resequencer brs_checker u_brs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_out_size    (o_out_size),
    .o_done_res    (o_done_res),
    .o_last_of_run (o_last_of_run)
);
